// File: hdl/irr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and rounding function for the interleaved rotary rotator.
package irr_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ROTATE = 1'b1;

  localparam logic CFG_PREFIX_ROWS    = 1'b0;
  localparam logic CFG_PAIRS_PER_HEAD = 1'b1;

  typedef struct packed {
    logic valid;
    logic pass;
    logic err;
  } irr_ctl_t;

  // Adds half an LSB, floors by 2^14 and saturates to signed 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [32:0] acc);
    logic signed [33:0] r;
    logic signed [19:0] q;
    r = 34'(acc) + 34'sd8192;
    q = r[33:14];
    if (q > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -20'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

endpackage

// File: hdl/irr_rotate.sv
`timescale 1ns / 1ps
// Multiply stage and round/saturate output register of the rotator.
module irr_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  irr_pkg::irr_ctl_t   ctl_i,
  input  logic signed [15:0]  even_i,
  input  logic signed [15:0]  odd_i,
  input  logic signed [15:0]  sine_i,
  input  logic signed [15:0]  cosine_i,
  output irr_pkg::irr_ctl_t   ctl_o,
  output logic signed [15:0]  even_o,
  output logic signed [15:0]  odd_o
);

  irr_pkg::irr_ctl_t  ctl3_q, ctl4_q;
  logic signed [15:0] ev3_q, od3_q;
  logic signed [31:0] ec_q, os_q, oc_q, es_q;
  logic signed [15:0] ev4_q, od4_q;
  logic signed [32:0] even_sum, odd_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (advance_i) begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ev3_q <= even_i;
      od3_q <= odd_i;
      ec_q  <= even_i * cosine_i;
      os_q  <= odd_i * sine_i;
      oc_q  <= odd_i * cosine_i;
      es_q  <= even_i * sine_i;
    end
  end

  assign even_sum = 33'(ec_q) - 33'(os_q);
  assign odd_sum  = 33'(oc_q) + 33'(es_q);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ev4_q <= ctl3_q.pass ? ev3_q : irr_pkg::round_sat(even_sum);
      od4_q <= ctl3_q.pass ? od3_q : irr_pkg::round_sat(odd_sum);
    end
  end

  assign ctl_o  = ctl4_q;
  assign even_o = ev4_q;
  assign odd_o  = od4_q;

endmodule

// File: hdl/interleaved_rope_rotator_top.sv
`timescale 1ns / 1ps
// A transaction passes the input register, the angle-memory read, the multiply stage and the round/saturate register.
// Throughput: one item per cycle while no result is stalled; the single read/write port
// of the angle memory is used once per item in the second stage.
// A stalled result freezes the whole pipeline, and the input stalls with it.
// Reset clears the valid bits and sets the registers to their defaults; the angle
// memory is not cleared and must be written before it is read.
module interleaved_rope_rotator_top #(
  parameter int MAX_PATCHES = 1024,
  parameter int MAX_PAIRS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [10:0]        row_index_i,
  input  logic [4:0]         pair_index_i,
  input  logic [9:0]         table_patch_i,
  input  logic signed [15:0] even_value_i,
  input  logic signed [15:0] odd_value_i,
  input  logic signed [15:0] sine_value_i,
  input  logic signed [15:0] cosine_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] even_result_o,
  output logic signed [15:0] odd_result_o,
  output logic               passed_through_o,
  output logic               range_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i
);

  localparam int Depth = MAX_PATCHES * MAX_PAIRS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FullW = 12 + $clog2(MAX_PAIRS + 1);

  logic [3:0] prefix_q;
  logic [5:0] pairs_q;

  logic             advance;
  irr_pkg::irr_ctl_t out_ctl;

  logic [10:0]      patch_rot, patch_sel;
  logic             is_prefix, patch_ok, pair_ok;
  logic [FullW-1:0] addr_full;

  logic             s1_valid_q, s1_op_q, s1_prefix_q, s1_err_q;
  logic [AddrW-1:0] s1_addr_q;
  logic signed [15:0] s1_ev_q, s1_od_q, s1_sin_q, s1_cos_q;

  irr_pkg::irr_ctl_t  s2_ctl_q;
  logic signed [15:0] s2_ev_q, s2_od_q;
  logic [31:0]        rd_q;
  logic [31:0]        angle_mem [Depth];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 4'd1;
      pairs_q  <= 6'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        irr_pkg::CFG_PREFIX_ROWS:    prefix_q <= cfg_data_i[3:0];
        irr_pkg::CFG_PAIRS_PER_HEAD: pairs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is held by the sink.
  assign advance    = !(out_ctl.valid && out_stall_i);
  assign in_stall_o = !advance;

  assign patch_rot = row_index_i - 11'(prefix_q);
  assign is_prefix = row_index_i < {7'd0, prefix_q};
  assign patch_sel = (operation_i == irr_pkg::OP_ROTATE) ? patch_rot : {1'b0, table_patch_i};
  assign patch_ok  = 32'(patch_sel) < MAX_PATCHES;
  assign pair_ok   = (32'(pair_index_i) < 32'(pairs_q)) && (32'(pair_index_i) < MAX_PAIRS);
  assign addr_full = FullW'(patch_sel) * FullW'(MAX_PAIRS) + FullW'(pair_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_ctl_q   <= '0;
    end else if (advance) begin
      s1_valid_q     <= in_valid_i;
      s2_ctl_q.valid <= s1_valid_q && (s1_op_q == irr_pkg::OP_ROTATE);
      s2_ctl_q.pass  <= s1_prefix_q || s1_err_q;
      s2_ctl_q.err   <= !s1_prefix_q && s1_err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q     <= operation_i;
      s1_prefix_q <= is_prefix;
      s1_err_q    <= !(patch_ok && pair_ok);
      s1_addr_q   <= addr_full[AddrW-1:0];
      s1_ev_q     <= even_value_i;
      s1_od_q     <= odd_value_i;
      s1_sin_q    <= sine_value_i;
      s1_cos_q    <= cosine_value_i;
      s2_ev_q     <= s1_ev_q;
      s2_od_q     <= s1_od_q;
    end
  end

  // Sine sits in the upper half of an entry, cosine in the lower.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s1_valid_q && (s1_op_q == irr_pkg::OP_WRITE) && !s1_err_q) begin
        angle_mem[s1_addr_q] <= {s1_sin_q, s1_cos_q};
      end
      rd_q <= angle_mem[s1_addr_q];
    end
  end

  irr_rotate u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ctl_i     (s2_ctl_q),
    .even_i    (s2_ev_q),
    .odd_i     (s2_od_q),
    .sine_i    (rd_q[31:16]),
    .cosine_i  (rd_q[15:0]),
    .ctl_o     (out_ctl),
    .even_o    (even_result_o),
    .odd_o     (odd_result_o)
  );

  assign out_valid_o      = out_ctl.valid;
  assign passed_through_o = out_ctl.pass;
  assign range_error_o    = out_ctl.err;

endmodule

// File: hdl/interleaved_rope_rotator_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the rotator, bound to the top level.
module interleaved_rope_rotator_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               operation_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] even_result_o,
  input logic signed [15:0] odd_result_o,
  input logic               passed_through_o,
  input logic               range_error_o
);

  // A stalled result transaction holds its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(even_result_o)
      && $stable(odd_result_o) && $stable(passed_through_o) && $stable(range_error_o))
    else $error("stalled result changed");

  // The input only stalls behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A range error always comes with the pass-through flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> passed_through_o)
    else $error("range error without pass-through");

  // An accepted rotate reaches the output when nothing stalls on the way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("rotate result missing");

endmodule

bind interleaved_rope_rotator_top interleaved_rope_rotator_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .operation_i      (operation_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .even_result_o    (even_result_o),
  .odd_result_o     (odd_result_o),
  .passed_through_o (passed_through_o),
  .range_error_o    (range_error_o)
);
